@@ sv/erg_pkg.sv @@
// ----------------------------------------------------------------------------
// erg_pkg
// Types, constants and lookup tables shared by the envelope ramp generator.
// ----------------------------------------------------------------------------
package erg_pkg;

  // quotient bits produced by the serial divider (level difference magnitude)
  localparam int unsigned QuoBits = 8;
  localparam int unsigned CntW    = $clog2(QuoBits);
  localparam int unsigned StepW   = 11;
  localparam int unsigned AccW    = 12;

  // multiplier that turns fifteenths into a 16-bit fraction of full scale
  localparam logic [15:0] FullTableStep = 16'd4369;

  // input transaction
  typedef struct packed {
    logic       action;
    logic [3:0] rate_code;
    logic [3:0] level_code;
    logic [2:0] param_kind;
    logic [7:0] start_value;
  } erg_in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] level;
    logic       segment_done;
  } erg_out_t;

  // input action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActTick  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_DIFF,
    S_DIV,
    S_FIN,
    S_TICK
  } erg_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul;
    logic diff;
    logic div_step;
    logic commit_start;
    logic commit_tick;
  } erg_cmd_t;

  // ticks per segment for each rate code
  function automatic logic [StepW-1:0] step_count(input logic [3:0] code);
    logic [StepW-1:0] s;
    case (code)
      4'd0:    s = 11'd1;
      4'd1:    s = 11'd4;
      4'd2:    s = 11'd6;
      4'd3:    s = 11'd8;
      4'd4:    s = 11'd10;
      4'd5:    s = 11'd14;
      4'd6:    s = 11'd18;
      4'd7:    s = 11'd24;
      4'd8:    s = 11'd36;
      4'd9:    s = 11'd64;
      4'd10:   s = 11'd100;
      4'd11:   s = 11'd160;
      4'd12:   s = 11'd240;
      4'd13:   s = 11'd340;
      4'd14:   s = 11'd600;
      default: s = 11'd1200;
    endcase
    return s;
  endfunction

  // full scale value for each parameter kind, unused kind gives zero
  function automatic logic [7:0] full_scale(input logic [2:0] kind);
    logic [7:0] f;
    case (kind)
      3'd0:    f = 8'd255;
      3'd1:    f = 8'd7;
      3'd2:    f = 8'd63;
      3'd3:    f = 8'd15;
      3'd4:    f = 8'd63;
      3'd5:    f = 8'd15;
      3'd6:    f = 8'd63;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

endpackage

@@ sv/erg_ctrl.sv @@
// ----------------------------------------------------------------------------
// erg_ctrl
// Sequencer for segment start and tick transactions, owns the handshakes.
// ----------------------------------------------------------------------------
module erg_ctrl
  import erg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output erg_cmd_t cmd
);

  erg_state_t      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // output slot can take a new result this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_action == ActTick) ? S_TICK : S_TGT;
        end
      end
      S_TGT: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CntW'(QuoBits - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit_start = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          cmd.commit_tick = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit_start || cmd.commit_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

@@ sv/erg_dp.sv @@
// ----------------------------------------------------------------------------
// erg_dp
// Datapath: target level, serial divider, ramp state and result register.
// ----------------------------------------------------------------------------
module erg_dp
  import erg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  erg_in_t  in_data,
  input  erg_cmd_t cmd,
  output erg_out_t out_data
);

  // captured start fields
  logic [3:0]         rate_r, rate_nxt;
  logic [3:0]         lcode_r, lcode_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [7:0]         start_r, start_nxt;

  // target and divider work registers
  logic [11:0]        prod_r, prod_nxt;
  logic signed [8:0]  diff_r, diff_nxt;
  logic               neg_r, neg_nxt;
  logic [7:0]         mag_r, mag_nxt;
  logic [7:0]         divd_r, divd_nxt;
  logic [StepW-1:0]   rem_r, rem_nxt;
  logic [7:0]         quo_r, quo_nxt;

  // ramp state
  logic [7:0]         cur_level_r, cur_level_nxt;
  logic signed [8:0]  delta_r, delta_nxt;
  logic               use_delta_r, use_delta_nxt;
  logic [StepW-1:0]   step_total_r, step_total_nxt;
  logic [StepW-1:0]   frac_inc_r, frac_inc_nxt;
  logic [AccW-1:0]    frac_acc_r, frac_acc_nxt;
  logic [StepW-1:0]   ticks_left_r, ticks_left_nxt;
  erg_out_t           out_r, out_nxt;

  // combinational helpers
  logic [StepW-1:0]   steps;
  logic [27:0]        tprod;
  logic [7:0]         target;
  logic signed [8:0]  diff_w;
  logic [StepW:0]     rem_sh;
  logic signed [10:0] lv;
  logic [AccW-1:0]    acc_sum;

  assign steps    = step_count(rate_r);
  assign out_data = out_r;

  // payload registers
  always_ff @(posedge clk) begin
    rate_r  <= rate_nxt;
    lcode_r <= lcode_nxt;
    kind_r  <= kind_nxt;
    start_r <= start_nxt;
    prod_r  <= prod_nxt;
    diff_r  <= diff_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    divd_r  <= divd_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    out_r   <= out_nxt;
  end

  // ramp state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_level_r  <= '0;
      delta_r      <= '0;
      use_delta_r  <= 1'b0;
      step_total_r <= StepW'(1);
      frac_inc_r   <= '0;
      frac_acc_r   <= '0;
      ticks_left_r <= '0;
    end else begin
      cur_level_r  <= cur_level_nxt;
      delta_r      <= delta_nxt;
      use_delta_r  <= use_delta_nxt;
      step_total_r <= step_total_nxt;
      frac_inc_r   <= frac_inc_nxt;
      frac_acc_r   <= frac_acc_nxt;
      ticks_left_r <= ticks_left_nxt;
    end
  end

  // field capture, target level, difference and divider step
  always_comb begin
    rate_nxt  = rate_r;
    lcode_nxt = lcode_r;
    kind_nxt  = kind_r;
    start_nxt = start_r;
    prod_nxt  = prod_r;
    diff_nxt  = diff_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    divd_nxt  = divd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;

    tprod  = 28'(prod_r) * 28'(FullTableStep);
    target = tprod[23:16];
    diff_w = $signed({1'b0, target}) - $signed({1'b0, start_r});
    rem_sh = {rem_r, divd_r[7]};

    if (cmd.capture) begin
      rate_nxt  = in_data.rate_code;
      lcode_nxt = in_data.level_code;
      kind_nxt  = in_data.param_kind;
      start_nxt = in_data.start_value;
    end
    if (cmd.mul) begin
      prod_nxt = 12'(lcode_r) * 12'(full_scale(kind_r));
    end
    if (cmd.diff) begin
      diff_nxt = diff_w;
      neg_nxt  = diff_w[8];
      mag_nxt  = diff_w[8] ? 8'(-diff_w) : diff_w[7:0];
      divd_nxt = diff_w[8] ? 8'(-diff_w) : diff_w[7:0];
      rem_nxt  = '0;
      quo_nxt  = '0;
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_step) begin
      divd_nxt = {divd_r[6:0], 1'b0};
      if (rem_sh >= {1'b0, steps}) begin
        rem_nxt = StepW'(rem_sh - {1'b0, steps});
        quo_nxt = {quo_r[6:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[StepW-1:0];
        quo_nxt = {quo_r[6:0], 1'b0};
      end
    end
  end

  // segment load and per-tick ramp update
  always_comb begin
    cur_level_nxt  = cur_level_r;
    delta_nxt      = delta_r;
    use_delta_nxt  = use_delta_r;
    step_total_nxt = step_total_r;
    frac_inc_nxt   = frac_inc_r;
    frac_acc_nxt   = frac_acc_r;
    ticks_left_nxt = ticks_left_r;
    out_nxt        = out_r;

    lv      = $signed({3'b000, cur_level_r})
            + (use_delta_r ? 11'(delta_r) : 11'sd0);
    acc_sum = frac_acc_r + {1'b0, frac_inc_r};
    if (acc_sum >= {1'b0, step_total_r}) begin
      lv = delta_r[8] ? (lv - 11'sd1) : (lv + 11'sd1);
    end

    if (cmd.commit_start) begin
      if ({3'b000, mag_r} > steps) begin
        use_delta_nxt = 1'b1;
        delta_nxt     = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
        frac_inc_nxt  = rem_r;
      end else begin
        use_delta_nxt = 1'b0;
        delta_nxt     = diff_r;
        frac_inc_nxt  = {3'b000, mag_r};
      end
      step_total_nxt = steps;
      ticks_left_nxt = steps;
      frac_acc_nxt   = '0;
      cur_level_nxt  = start_r;
      out_nxt        = '{level: start_r, segment_done: 1'b0};
    end else if (cmd.commit_tick) begin
      if (ticks_left_r == '0) begin
        // segment already over: hold the level
        out_nxt = '{level: cur_level_r, segment_done: 1'b1};
      end else begin
        if (acc_sum >= {1'b0, step_total_r}) begin
          frac_acc_nxt = acc_sum - {1'b0, step_total_r};
        end else begin
          frac_acc_nxt = acc_sum;
        end
        // saturate to the 8-bit level range
        if (lv < 11'sd0) begin
          cur_level_nxt = '0;
        end else if (lv > 11'sd255) begin
          cur_level_nxt = 8'd255;
        end else begin
          cur_level_nxt = lv[7:0];
        end
        ticks_left_nxt = ticks_left_r - 1'b1;
        out_nxt = '{level: cur_level_nxt, segment_done: (ticks_left_r == StepW'(1))};
      end
    end
  end

endmodule

@@ sv/envelope_ramp_generator_core.sv @@
// ----------------------------------------------------------------------------
// envelope_ramp_generator_core
// One envelope segment generator: segment start and per-tick level ramp.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid / in_stall        | in_data  (erg_in_t)
//  result   | out_valid / out_stall      | out_data (erg_out_t)
//
// start: multiply, difference, eight quotient steps, then commit; with the output
//   free the input reopens in the same cycle that the result appears.
// tick: ramp update at commit; with the output free the input reopens in the same cycle that the result appears.
// one transaction in flight; the next is accepted while the result register
//   still holds the previous result, and a stalled result holds the commit.
// reset is synchronous; it clears the ramp state, the sequencer state and the result valid flag.
// ----------------------------------------------------------------------------
module envelope_ramp_generator_core
  import erg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  erg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output erg_out_t out_data
);

  erg_cmd_t cmd;

  // sequencer
  erg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic and state
  erg_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

@@ sv/erg_checker.sv @@
// ----------------------------------------------------------------------------
// erg_checker
// Port-level checks for the envelope ramp generator, bound to the top level.
// ----------------------------------------------------------------------------
module erg_checker
  import erg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input erg_out_t out_data
);

  // reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // one transaction at a time: accepting closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open after a transaction was accepted");

  // a new result only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind envelope_ramp_generator_core erg_checker u_erg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
